[sv/fat32ct_pkg.sv]
package fat32ct_pkg;

  // entry counts, indexes and the search hint all fit this width
  localparam int unsigned CntW    = 17;
  localparam int unsigned CntMax  = 131071;
  localparam int unsigned CfgIdxW = 2;

  localparam logic [2:0] CMD_WRITE = 3'd0;
  localparam logic [2:0] CMD_READ  = 3'd1;
  localparam logic [2:0] CMD_NEXT  = 3'd2;
  localparam logic [2:0] CMD_ALLOC = 3'd3;
  localparam logic [2:0] CMD_FREE  = 3'd4;
  localparam logic [2:0] CMD_COUNT = 3'd5;

  localparam logic [1:0] ST_OK     = 2'd0;
  localparam logic [1:0] ST_NOFREE = 2'd1;
  localparam logic [1:0] ST_RANGE  = 2'd2;
  localparam logic [1:0] ST_LOOP   = 2'd3;

  localparam logic [CfgIdxW-1:0] REG_FAT_ENTRIES = 2'd0;
  localparam logic [CfgIdxW-1:0] REG_DATA_START  = 2'd1;
  localparam logic [CfgIdxW-1:0] REG_SPC         = 2'd2;
  localparam logic [CfgIdxW-1:0] REG_EOC         = 2'd3;

  localparam logic [31:0] EOC_MARK    = 32'h0FFF_FFFF;
  localparam logic [31:0] NEXT_MASK   = 32'h0FFF_FFFF;
  localparam logic [31:0] FIRST_DATA  = 32'd2;

  localparam logic [CntW-1:0] RST_FAT_ENTRIES = 17'd65536;
  localparam logic [31:0]     RST_EOC         = 32'h0FFF_FFF8;

endpackage

[sv/fat32_cluster_table.sv]
// One item at a time: writes and bad indexes go straight to the output, read/next wait
// on the table read, allocate scans and then forms the first sector, count sweeps every
// entry, and free walks the chain zeroing each entry until it ends or hits a free one.
// Scans probe one entry per cycle through the registered table read port, and chain
// walks issue one table read per link.
// Reset clears the hint and control and loads the config defaults; the table keeps garbage until written.
module fat32_cluster_table
  import fat32ct_pkg::*;
#(
  parameter int unsigned TABLE_DEPTH = 65536
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  // command items
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic [2:0]         command_i,
  input  logic [15:0]        cluster_index_i,
  input  logic [31:0]        entry_value_i,
  // result items
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic [31:0]        result_value_o,
  output logic [1:0]         status_o,
  output logic [31:0]        first_sector_o,
  // config writes
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic [CfgIdxW-1:0] cfg_index_i,
  input  logic [31:0]        cfg_data_i
);

  localparam int unsigned AW = $clog2(TABLE_DEPTH);
  // effective entry count can never exceed what the 17-bit register holds
  localparam int unsigned DepthCap = (TABLE_DEPTH < CntMax) ? TABLE_DEPTH : CntMax;

  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_RD   = 4'd1;  // waiting on read data for read/next
  localparam logic [3:0] S_SCAN = 4'd2;  // allocate or count sweep
  localparam logic [3:0] S_FCHK = 4'd3;  // free: check link, issue read
  localparam logic [3:0] S_FDAT = 4'd4;  // free: examine entry, zero it
  localparam logic [3:0] S_MUL  = 4'd5;  // sector offset product
  localparam logic [3:0] S_SEC  = 4'd6;  // add data start
  localparam logic [3:0] S_PUSH = 4'd7;  // hand result to output register

  // config
  logic [CntW-1:0] fat_entries_q;
  logic [31:0]     data_start_q;
  logic [7:0]      spc_q;
  logic [31:0]     eoc_q;
  logic [CntW-1:0] n_w;

  // table memory
  logic [31:0]   fat_mem_q [TABLE_DEPTH];
  logic [31:0]   mem_rd_q;
  logic          mem_we, mem_re;
  logic [AW-1:0] mem_waddr, mem_raddr;
  logic [31:0]   mem_wdata;

  // control and work registers
  logic [3:0]      state_q, state_d;
  logic [2:0]      cmd_q, cmd_d;
  logic [31:0]     cur_q, cur_d;
  logic [CntW-1:0] scan_i_q, scan_i_d;
  logic [CntW-1:0] scan_k_q, scan_k_d;
  logic [CntW-1:0] ra_q, ra_d;
  logic            rv_q, rv_d;
  logic [CntW-1:0] hint_q, hint_d;
  logic [31:0]     res_q, res_d;
  logic [1:0]      stat_q, stat_d;
  logic [31:0]     sec_q, sec_d;

  // output register
  logic        ov_q, ov_d;
  logic [31:0] out_res_q, out_res_d;
  logic [1:0]  out_stat_q, out_stat_d;
  logic [31:0] out_sec_q, out_sec_d;

  logic            scan_issue;
  logic [CntW-1:0] scan_inc;

  assign n_w = (fat_entries_q < CntW'(DepthCap)) ? fat_entries_q : CntW'(DepthCap);

  assign cfg_ready_o    = 1'b1;
  assign in_ready_o     = (state_q == S_IDLE);
  assign out_valid_o    = ov_q;
  assign result_value_o = out_res_q;
  assign status_o       = out_stat_q;
  assign first_sector_o = out_sec_q;

  // config registers; the user must write them only while the block is idle, the block does not enforce it
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fat_entries_q <= RST_FAT_ENTRIES;
      data_start_q  <= '0;
      spc_q         <= 8'd1;
      eoc_q         <= RST_EOC;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        REG_FAT_ENTRIES: fat_entries_q <= cfg_data_i[CntW-1:0];
        REG_DATA_START:  data_start_q  <= cfg_data_i;
        REG_SPC:         spc_q         <= cfg_data_i[7:0];
        REG_EOC:         eoc_q         <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // one write port, one registered read port
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      fat_mem_q[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      mem_rd_q <= fat_mem_q[mem_raddr];
    end
  end

  // scan sweep: one probe per cycle until n probes are out
  assign scan_issue = (state_q == S_SCAN) && (scan_k_q < n_w);
  assign scan_inc   = scan_i_q + CntW'(1);

  always_comb begin
    state_d    = state_q;
    cmd_d      = cmd_q;
    cur_d      = cur_q;
    scan_i_d   = scan_i_q;
    scan_k_d   = scan_k_q;
    ra_d       = ra_q;
    rv_d       = scan_issue;
    hint_d     = hint_q;
    res_d      = res_q;
    stat_d     = stat_q;
    sec_d      = sec_q;
    ov_d       = ov_q;
    out_res_d  = out_res_q;
    out_stat_d = out_stat_q;
    out_sec_d  = out_sec_q;
    mem_we     = 1'b0;
    mem_waddr  = '0;
    mem_wdata  = '0;
    mem_re     = 1'b0;
    mem_raddr  = '0;

    if (ov_q && out_ready_i) begin
      ov_d = 1'b0;
    end

    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_d    = command_i;
          res_d    = '0;
          stat_d   = ST_OK;
          sec_d    = '0;
          scan_k_d = '0;
          cur_d    = 32'(cluster_index_i);
          state_d  = S_PUSH;
          case (command_i)
            CMD_WRITE, CMD_READ, CMD_NEXT: begin
              if (CntW'(cluster_index_i) >= n_w) begin
                stat_d = ST_RANGE;
              end else if (command_i == CMD_WRITE) begin
                mem_we    = 1'b1;
                mem_waddr = AW'(cluster_index_i);
                mem_wdata = entry_value_i;
              end else begin
                mem_re    = 1'b1;
                mem_raddr = AW'(cluster_index_i);
                state_d   = S_RD;
              end
            end
            CMD_ALLOC: begin
              scan_i_d = (hint_q < n_w) ? hint_q : '0;
              state_d  = S_SCAN;
            end
            CMD_FREE: begin
              state_d = S_FCHK;
            end
            CMD_COUNT: begin
              scan_i_d = '0;
              state_d  = S_SCAN;
            end
            default: ;  // unused codes: all-zero result
          endcase
        end
      end

      S_RD: begin
        res_d   = (cmd_q == CMD_READ) ? mem_rd_q : (mem_rd_q & NEXT_MASK);
        state_d = S_PUSH;
      end

      S_SCAN: begin
        if (scan_issue) begin
          mem_re    = 1'b1;
          mem_raddr = AW'(scan_i_q);
          ra_d      = scan_i_q;
          scan_k_d  = scan_k_q + CntW'(1);
          scan_i_d  = (scan_inc >= n_w) ? '0 : scan_inc;
        end
        if (cmd_q == CMD_ALLOC) begin
          if (rv_q && (mem_rd_q == '0)) begin
            // first free entry: mark end of chain, move hint past it
            mem_we    = 1'b1;
            mem_waddr = AW'(ra_q);
            mem_wdata = EOC_MARK;
            hint_d    = ra_q + CntW'(1);
            res_d     = 32'(ra_q);
            state_d   = S_MUL;
          end else if (!scan_issue && !rv_q) begin
            stat_d  = ST_NOFREE;
            state_d = S_PUSH;
          end
        end else begin
          if (rv_q && (mem_rd_q == '0)) begin
            res_d = res_q + 32'd1;
          end
          if (!scan_issue && !rv_q) begin
            state_d = S_PUSH;
          end
        end
      end

      S_FCHK: begin
        if ((cur_q == '0) || (cur_q >= eoc_q)) begin
          state_d = S_PUSH;
        end else if (cur_q >= 32'(n_w)) begin
          stat_d  = ST_RANGE;
          state_d = S_PUSH;
        end else begin
          mem_re    = 1'b1;
          mem_raddr = AW'(cur_q);
          state_d   = S_FDAT;
        end
      end

      S_FDAT: begin
        if (mem_rd_q == '0) begin
          // already free: loop back or link into a free entry
          stat_d  = ST_LOOP;
          state_d = S_PUSH;
        end else begin
          mem_we    = 1'b1;
          mem_waddr = AW'(cur_q);
          mem_wdata = '0;
          res_d     = res_q + 32'd1;
          cur_d     = mem_rd_q;
          state_d   = S_FCHK;
        end
      end

      S_MUL: begin
        sec_d   = (res_q - FIRST_DATA) * 32'(spc_q);
        state_d = S_SEC;
      end

      S_SEC: begin
        sec_d   = data_start_q + sec_q;
        state_d = S_PUSH;
      end

      S_PUSH: begin
        if (!ov_q || out_ready_i) begin
          ov_d       = 1'b1;
          out_res_d  = res_q;
          out_stat_d = stat_q;
          out_sec_d  = sec_q;
          state_d    = S_IDLE;
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      rv_q    <= 1'b0;
      hint_q  <= '0;
      ov_q    <= 1'b0;
    end else begin
      state_q <= state_d;
      rv_q    <= rv_d;
      hint_q  <= hint_d;
      ov_q    <= ov_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cmd_q      <= cmd_d;
    cur_q      <= cur_d;
    scan_i_q   <= scan_i_d;
    scan_k_q   <= scan_k_d;
    ra_q       <= ra_d;
    res_q      <= res_d;
    stat_q     <= stat_d;
    sec_q      <= sec_d;
    out_res_q  <= out_res_d;
    out_stat_q <= out_stat_d;
    out_sec_q  <= out_sec_d;
  end

endmodule
